// ----- hdl/dvru_pkg.sv -----
`default_nettype none
package dvru_pkg;
   localparam int NODES = 64;
   localparam int PORTS = 16;
   localparam int NODE_W = 6;
   localparam int PORT_W = 4;
   localparam int COST_W = 16;
   localparam int COUNT_W = 7;

   localparam logic [0:0] OP_LINK = 1'b0;
   localparam logic [0:0] OP_VECTOR = 1'b1;
   localparam logic [0:0] CSR_OWN_ID = 1'b0;
   localparam logic [0:0] CSR_INFINITY = 1'b1;

   typedef struct packed {
      logic [0:0] operation;
      logic [3:0] port;
      logic [5:0] node_id;
      logic [15:0] cost;
      logic first;
      logic last;
   } req_word_type;

   typedef struct packed {
      logic [5:0] dest_id;
      logic [15:0] route_cost;
      logic [3:0] next_port;
      logic entry_changed;
      logic packet_done;
      logic [6:0] change_count;
      logic send_all;
      logic send_update;
   } rsp_word_type;
endpackage
`default_nettype wire

// ----- hdl/distance_vector_route_update.sv -----
`default_nettype none
// channel | direction | word          | accepted when
// req     | in        | req_word_type | req_valid && !req_stall
// rsp     | out       | rsp_word_type | rsp_valid && !rsp_stall
// csr     | in        | index, data   | csr_write
// Each word is handled as a route memory read, then a modify and write back.
// A new req word is taken once the result is loaded into the output register.
// Reset runs a clearing pass over all 64 route memory entries; req_stall stays
// high during it. rsp_stall holds the output register and, while it is full,
// also holds off the next req word.
module distance_vector_route_update (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire dvru_pkg::req_word_type req_word,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output dvru_pkg::rsp_word_type rsp_word,
   input  wire logic csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [15:0] csr_data
);
   import dvru_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_CALC  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [NODE_W:0] clr_ff, clr_in;
   logic [NODE_W-1:0] own_ff;
   logic [COST_W-1:0] inf_ff;

   // route memory: {cost, port}
   logic [COST_W+PORT_W-1:0] route_mem [NODES];
   logic [COST_W+PORT_W-1:0] rd_ff;
   logic mem_we;
   logic [NODE_W-1:0] mem_wa;
   logic [COST_W+PORT_W-1:0] mem_wd;

   logic [NODES-1:0] mark_ff, mark_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic sall_ff, sall_in;
   logic [COST_W-1:0] lcost_ff [PORTS];
   logic [NODE_W-1:0] lnb_ff [PORTS];
   logic [PORTS-1:0] lknown_ff;
   req_word_type item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;
   logic take;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign take = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   always_ff @(posedge clock) begin
      if (csr_write) begin
         if (csr_index == CSR_OWN_ID) own_ff <= csr_data[NODE_W-1:0];
         else own_ff <= own_ff;
         if (csr_index == CSR_INFINITY) inf_ff <= csr_data;
      end
      if (reset) begin
         own_ff <= '0;
         inf_ff <= '1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) route_mem[mem_wa] <= mem_wd;
      if (take) rd_ff <= route_mem[req_word.node_id];
      if (take) item_ff <= req_word;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lknown_ff <= '0;
         for (int i = 0; i < PORTS; i++) lcost_ff[i] <= '1;
      end else if (take && req_word.operation == OP_LINK) begin
         lknown_ff[req_word.port] <= 1'b1;
         lcost_ff[req_word.port] <= req_word.cost;
         lnb_ff[req_word.port] <= req_word.node_id;
      end
   end

   logic [COST_W:0] sum;
   logic [COST_W-1:0] nc, cur;
   logic [PORT_W-1:0] cport, fb_port;
   logic fb_hit, chg;
   logic [COST_W-1:0] upd_cost;
   logic [PORT_W-1:0] new_port;
   logic [NODES-1:0] mk;
   logic [COUNT_W-1:0] tot;
   logic sa;

   always_comb begin
      fb_hit = 1'b0;
      fb_port = '0;
      for (int p = PORTS - 1; p >= 0; p--) begin
         if (lknown_ff[p] && lnb_ff[p] == item_ff.node_id) begin
            fb_hit = 1'b1;
            fb_port = PORT_W'(p);
         end
      end
   end

   always_comb begin
      cur = rd_ff[COST_W+PORT_W-1:PORT_W];
      cport = rd_ff[PORT_W-1:0];
      sum = {1'b0, lcost_ff[item_ff.port]} + {1'b0, item_ff.cost};
      nc = (sum > {1'b0, inf_ff}) ? inf_ff : sum[COST_W-1:0];
      mk = item_ff.first ? '0 : mark_ff;
      tot = item_ff.first ? '0 : total_ff;
      sa = item_ff.first ? 1'b0 : sall_ff;
      chg = 1'b0;
      upd_cost = cur;
      new_port = cport;
      if (item_ff.operation == OP_VECTOR && item_ff.node_id != own_ff) begin
         if (cport == item_ff.port) begin
            if (cur != nc) begin
               chg = 1'b1;
               upd_cost = nc;
               if (cur < nc && fb_hit && lcost_ff[fb_port] <= nc) begin
                  upd_cost = lcost_ff[fb_port];
                  new_port = fb_port;
                  sa = 1'b1;
               end
            end
         end else if (cur > nc) begin
            chg = 1'b1;
            upd_cost = nc;
            new_port = item_ff.port;
         end
      end
      if (chg && !mk[item_ff.node_id]) begin
         mk[item_ff.node_id] = 1'b1;
         if (tot != '1) tot = tot + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      mem_we = 1'b0;
      mem_wa = item_ff.node_id;
      mem_wd = {upd_cost, new_port};
      mark_in = mark_ff;
      total_in = total_ff;
      sall_in = sall_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[NODE_W-1:0];
            mem_wd = {{COST_W{1'b1}}, {PORT_W{1'b0}}};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (NODE_W+1)'(NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_IDLE;
            mem_we = chg;
            if (item_ff.operation == OP_VECTOR) begin
               mark_in = mk;
               total_in = tot;
               sall_in = sa;
            end
            rsp_valid_in = 1'b1;
            rsp_in.dest_id = item_ff.node_id;
            rsp_in.route_cost = upd_cost;
            rsp_in.next_port = new_port;
            rsp_in.entry_changed = chg;
            rsp_in.packet_done = (item_ff.operation == OP_VECTOR) && item_ff.last;
            rsp_in.change_count = (item_ff.operation == OP_VECTOR) ? tot : total_ff;
            rsp_in.send_all = (item_ff.operation == OP_VECTOR) ? sa : sall_ff;
            rsp_in.send_update = (item_ff.operation == OP_VECTOR) && item_ff.last
                                 && (tot != '0);
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         mark_ff <= '0;
         total_ff <= '0;
         sall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         mark_ff <= mark_in;
         total_ff <= total_in;
         sall_ff <= sall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |=> rsp_valid_ff) else $error("result lost");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !take) else $error("word taken while busy");
   a_count_marks: assert property (@(posedge clock) disable iff (reset)
      total_ff == COUNT_W'($countones(mark_ff))) else $error("count mismatch");
endmodule
`default_nettype wire
